FILE: sv/swmm_pkg.sv
// Shared types and constants of the sliding-window min/max unit.
package swmm_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int CFG_WIDTH    = 7;
    localparam int AGE_W        = $clog2(WINDOW_MAX + 1);
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = 3;

    // Register index, taken from paddr[2].
    localparam logic REG_WINDOW_SIZE = 1'b0;

    typedef logic [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [AGE_W-1:0]        age_t;

    typedef struct packed {
        logic    valid;
        sample_t value;
        age_t    age;
    } entry_t;

    // Per-transaction control from the top level to each deque.
    typedef struct packed {
        logic    step;   // sample transaction accepted
        logic    fresh;  // sample starts a new stream
        logic    flush;  // config write, drop everything
        sample_t sample;
    } swmm_ctl_t;

    // Control broadcast to every cell of one deque.
    typedef struct packed {
        logic    step;
        logic    fresh;
        logic    flush;
        logic    shift;  // head leaves the window, entries move one cell left
        sample_t sample;
    } cell_ctl_t;

endpackage

FILE: sv/sliding_window_min_max_unit.sv
// Sliding-window minimum/maximum unit: two monotonic deques built as cell rows.
//
// Each accepted sample transaction updates a minimum deque and a maximum deque,
// each a row of 64 cells holding (value, age) entries with the oldest at cell 0.
// All cells compare their entry against the new sample in parallel and decide
// locally, from their own entry, their right neighbor and their left neighbor's
// keep flag, whether to keep an entry, take the new sample or go empty; an entry
// whose age reaches the window moves the row one cell left in the same cycle.
// The unit therefore accepts one sample every cycle; the result appears in the
// output register on the cycle after its sample is accepted, and the input only
// stalls while that register holds a result the consumer is stalling. Once
// window_size samples have arrived since the last start_req (or config write),
// every sample yields one result transaction with the window minimum and
// maximum; before that no result is produced. window_size is the APB register
// at paddr[2] == 0 (0 acts as 1, values above 64 act as 64); writing it restarts
// the stream, while writes with paddr[2] set are ignored. There is no
// clearing pass: empty cells are tracked by valid flags.
module sliding_window_min_max_unit
    import swmm_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    // sample channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           start_req,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] window_min,
    output logic signed [SAMPLE_WIDTH-1:0] window_max,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ADDR_W-1:0]              paddr,
    input  logic [DATA_W-1:0]              pwdata,
    output logic [DATA_W-1:0]              prdata,
    output logic                           pready
);

    logic [CFG_WIDTH-1:0] window_size_reg, window_size_next;
    age_t                 seen_reg, seen_next;
    logic                 out_valid_reg, out_valid_next;
    sample_t              min_reg, min_next;
    sample_t              max_reg, max_next;

    logic      cfg_wr;
    logic      cfg_win_wr;
    logic      reg_idx;
    age_t      w_eff;
    age_t      seen_base;
    age_t      seen_step;
    logic      produce;
    logic      step;
    swmm_ctl_t ctl;
    sample_t   min_head;
    sample_t   max_head;

    // ---------------- configuration port ----------------
    assign pready     = 1'b1;
    assign reg_idx    = paddr[2];
    assign cfg_wr     = psel && penable && pwrite && pready;
    // only a write to the window register restarts the stream
    assign cfg_win_wr = cfg_wr && (reg_idx == REG_WINDOW_SIZE);

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_WINDOW_SIZE)
        begin
            prdata = DATA_W'(window_size_reg);
        end
    end

    always_comb
    begin
        window_size_next = window_size_reg;
        if (cfg_win_wr)
        begin
            window_size_next = pwdata[CFG_WIDTH-1:0];
        end
    end

    // Effective window, clamped to 1..WINDOW_MAX.
    always_comb
    begin
        priority if (window_size_reg == '0)
        begin
            w_eff = age_t'(1);
        end
        else if (int'(window_size_reg) > WINDOW_MAX)
        begin
            w_eff = age_t'(WINDOW_MAX);
        end
        else
        begin
            w_eff = age_t'(window_size_reg);
        end
    end

    // ---------------- handshake ----------------
    // Output register frees the input side unless a result is held.
    assign in_stall = out_valid_reg && out_stall;
    assign step     = in_valid && !in_stall;

    assign ctl = '{step: step, fresh: start_req, flush: cfg_win_wr, sample: sample};

    // ---------------- deques ----------------
    swmm_deque u_min_deque (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .is_max    (1'b0),
        .win       (w_eff),
        .head_next (min_head)
    );

    swmm_deque u_max_deque (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .is_max    (1'b1),
        .win       (w_eff),
        .head_next (max_head)
    );

    // ---------------- fill count ----------------
    always_comb
    begin
        seen_base = start_req ? '0 : seen_reg;
        seen_step = (seen_base < w_eff) ? (seen_base + age_t'(1)) : seen_base;
        produce   = (seen_step == w_eff);

        seen_next = seen_reg;
        if (cfg_win_wr)
        begin
            seen_next = '0;
        end
        else if (step)
        begin
            seen_next = seen_step;
        end
    end

    // ---------------- result register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        if (step)
        begin
            out_valid_next = produce && !cfg_win_wr;
            min_next       = min_head;
            max_next       = max_head;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign window_min = min_reg;
    assign window_max = max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= CFG_WIDTH'(1);
            seen_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            window_size_reg <= window_size_next;
            seen_reg        <= seen_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        max_reg <= max_next;
    end

    // ---------------- assertions ----------------
    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_win_wr |=> (seen_reg == '0))
        else $error("config write did not restart the fill count");

    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= w_eff)
        else $error("fill count exceeds the window");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (step && produce && !cfg_win_wr) |=> ($signed(min_reg) <= $signed(max_reg)))
        else $error("window minimum above window maximum");

    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step && start_req && !cfg_win_wr) |=> (out_valid_reg == (w_eff == age_t'(1))))
        else $error("result after stream start does not match window");

endmodule

FILE: sv/swmm_cell.sv
// One deque entry: keeps, replaces or drops its entry from local compares.
module swmm_cell
    import swmm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      is_max,
    input  entry_t    right_q,
    input  logic      left_keep,
    output entry_t    own_q,
    output logic      keep,
    output sample_t   nxt_value
);

    logic    valid_reg, valid_next;
    sample_t value_reg, value_next;
    age_t    age_reg, age_next;
    entry_t  src;
    logic    src_ok;
    logic    worse;
    logic    step_valid;
    sample_t step_value;
    age_t    step_age;

    assign own_q = '{valid: valid_reg, value: value_reg, age: age_reg};

    always_comb
    begin
        src    = ctl.shift ? right_q : own_q;
        src_ok = src.valid && !ctl.fresh;
        if (is_max)
        begin
            worse = $signed(src.value) <= $signed(ctl.sample);
        end
        else
        begin
            worse = $signed(ctl.sample) <= $signed(src.value);
        end
        keep = src_ok && !worse;

        if (keep)
        begin
            step_valid = 1'b1;
            step_value = src.value;
            step_age   = src.age + age_t'(1);
        end
        else if (left_keep)
        begin
            // first free slot takes the new sample
            step_valid = 1'b1;
            step_value = ctl.sample;
            step_age   = '0;
        end
        else
        begin
            step_valid = 1'b0;
            step_value = src.value;
            step_age   = src.age;
        end
    end

    assign nxt_value = step_value;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        if (ctl.flush)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.step)
        begin
            valid_next = step_valid;
            value_next = step_value;
            age_next   = step_age;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

endmodule

FILE: sv/swmm_deque.sv
// Monotonic deque built as a row of WINDOW_MAX cells, head in cell 0.
module swmm_deque
    import swmm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  swmm_ctl_t ctl,
    input  logic      is_max,
    input  age_t      win,
    output sample_t   head_next
);

    entry_t    own_q  [WINDOW_MAX];
    entry_t    right_q[WINDOW_MAX];
    logic      keep   [WINDOW_MAX];
    logic      left_k [WINDOW_MAX];
    sample_t   nxt_v  [WINDOW_MAX];
    cell_ctl_t cctl;
    logic      shift;

    // Head ages out when its incremented age reaches the window.
    assign shift = !ctl.fresh && own_q[0].valid && ((own_q[0].age + age_t'(1)) >= win);

    assign cctl = '{step: ctl.step, fresh: ctl.fresh, flush: ctl.flush,
                    shift: shift, sample: ctl.sample};

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            if (gi == WINDOW_MAX - 1)
            begin : g_last
                assign right_q[gi] = '0;
            end
            else
            begin : g_mid
                assign right_q[gi] = own_q[gi+1];
            end

            if (gi == 0)
            begin : g_head
                assign left_k[gi] = 1'b1;
            end
            else
            begin : g_body
                assign left_k[gi] = keep[gi-1];
            end

            swmm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (cctl),
                .is_max    (is_max),
                .right_q   (right_q[gi]),
                .left_keep (left_k[gi]),
                .own_q     (own_q[gi]),
                .keep      (keep[gi]),
                .nxt_value (nxt_v[gi])
            );
        end
    endgenerate

    assign head_next = nxt_v[0];

endmodule
